// File: rtl/bpa_pkg.sv
// Shared constants, codes and types of the bitmap page allocator.
// Every other file of the block imports this package.
package bpa_pkg;

  localparam int POOL_PAGES = 1024;
  localparam int PAGE_BYTES = 4096;

  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;
  localparam int ADDR_W    = 32;
  localparam int CNT_W     = 11;

  localparam int WORD_BITS = (POOL_PAGES >= 64) ? 32 : 4;
  localparam int WB_W      = $clog2(WORD_BITS);
  localparam int IDX_W     = $clog2(POOL_PAGES);
  localparam int ROW_W     = IDX_W - WB_W;
  localparam int MEM_AW    = ROW_W + 1;
  localparam int SIZE_W    = $clog2(POOL_PAGES + 1);
  localparam int PB_W      = $clog2(PAGE_BYTES + 1);
  localparam int PROD_W    = CFG_W + PB_W;

  // The page size is a power of two, so byte and page numbers differ by a shift.
  localparam int PB_SHIFT  = $clog2(PAGE_BYTES);

  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_FIRST = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_USER_FIRST   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_USER_END     = CFG_IDX_W'(2);

  localparam logic [CFG_W-1:0] KERNEL_FIRST_RST = CFG_W'(256);
  localparam logic [CFG_W-1:0] USER_FIRST_RST   = CFG_W'(1280);
  localparam logic [CFG_W-1:0] USER_END_RST     = CFG_W'(2304);

  localparam logic [1:0] POOL_KERNEL = 2'd0;
  localparam logic [1:0] POOL_USER   = 2'd1;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_NOSPACE = 3'd2,
    ST_BADPOOL = 3'd3,
    ST_NOTUSED = 3'd4,
    ST_RANGE   = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_MARK,
    S_DIV_LOAD,
    S_RANGE,
    S_CHECK,
    S_UNMARK,
    S_FINISH
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLR,
    OP_LATCH,
    OP_DECODE,
    OP_SCAN,
    OP_SET,
    OP_DIV_LOAD,
    OP_RANGE,
    OP_CHECK,
    OP_UNSET,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    status_t code;
  } cmd_t;

  typedef struct packed {
    logic clr_end;
    logic is_free;
    logic cnt_zero;
    logic pool_bad;
    logic no_room;
    logic addr_bad;
    logic scan_hit;
    logic scan_miss;
    logic range_bad;
    logic pass_end;
    logic any_used;
  } sts_t;

endpackage

// File: rtl/bpa_if.sv
// Request and result channel interfaces of the bitmap page allocator.
// Depends on bpa_pkg for the field widths.
interface bpa_req_if;
  import bpa_pkg::*;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [1:0]        pool;
  logic [ADDR_W-1:0] address;
  logic [CNT_W-1:0]  page_count;
  modport source(output valid, mode, pool, address, page_count, input ready);
  modport sink(input valid, mode, pool, address, page_count, output ready);
endinterface

interface bpa_res_if;
  import bpa_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] page_address;
  logic [2:0]        status;
  modport source(output valid, page_address, status, input ready);
  modport sink(input valid, page_address, status, output ready);
endinterface

// File: rtl/bpa_div.sv
// Divider by the constant page size; the size is a power of two, so the
// quotient is a registered right shift. Depends on bpa_pkg for the widths.
module bpa_div (
  input  logic                       clk,
  input  logic                       start,
  input  logic [bpa_pkg::ADDR_W-1:0] dividend,
  output logic [bpa_pkg::ADDR_W-1:0] quotient
);
  import bpa_pkg::*;

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend >> PB_SHIFT;
    end
  end

endmodule

// File: rtl/bpa_ctrl.sv
// Sequencer of the bitmap page allocator: walks each request through its steps.
// Depends on bpa_pkg for the state, command and status types.
module bpa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  bpa_pkg::sts_t sts,
  output bpa_pkg::cmd_t cmd
);
  import bpa_pkg::*;

  state_t  state, state_next;
  status_t result_code, result_code_next;
  logic    out_valid_next;
  logic    load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLR;
      out_valid   <= 1'b0;
      result_code <= ST_OK;
    end else begin
      state       <= state_next;
      out_valid   <= out_valid_next;
      result_code <= result_code_next;
    end
  end

  always_comb begin
    state_next       = state;
    result_code_next = result_code;
    unique case (state)
      S_CLR: begin
        if (sts.clr_end) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (sts.cnt_zero) begin
          state_next       = S_FINISH;
          result_code_next = ST_ZERO;
        end else if (!sts.is_free) begin
          if (sts.pool_bad) begin
            state_next       = S_FINISH;
            result_code_next = ST_BADPOOL;
          end else if (sts.no_room) begin
            state_next       = S_FINISH;
            result_code_next = ST_NOSPACE;
          end else begin
            state_next = S_SCAN;
          end
        end else if (sts.addr_bad) begin
          state_next       = S_FINISH;
          result_code_next = ST_BADPOOL;
        end else begin
          state_next = S_DIV_LOAD;
        end
      end
      S_SCAN: begin
        if (sts.scan_hit) begin
          state_next = S_MARK;
        end else if (sts.scan_miss) begin
          state_next       = S_FINISH;
          result_code_next = ST_NOSPACE;
        end
      end
      S_MARK: begin
        if (sts.pass_end) begin
          state_next       = S_FINISH;
          result_code_next = ST_OK;
        end
      end
      S_DIV_LOAD: begin
        state_next = S_RANGE;
      end
      S_RANGE: begin
        if (sts.range_bad) begin
          state_next       = S_FINISH;
          result_code_next = ST_RANGE;
        end else begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.pass_end) begin
          if (sts.any_used) begin
            state_next = S_UNMARK;
          end else begin
            state_next       = S_FINISH;
            result_code_next = ST_NOTUSED;
          end
        end
      end
      S_UNMARK: begin
        if (sts.pass_end) begin
          state_next       = S_FINISH;
          result_code_next = ST_OK;
        end
      end
      S_FINISH: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_CLR;
    endcase
  end

  always_comb begin
    load     = (state == S_FINISH) && (!out_valid || out_ready);
    in_ready = (state == S_IDLE);
    cmd.code = result_code;
    unique case (state)
      S_CLR:      cmd.op = OP_CLR;
      S_IDLE:     cmd.op = in_valid ? OP_LATCH : OP_NONE;
      S_DECODE:   cmd.op = OP_DECODE;
      S_SCAN:     cmd.op = OP_SCAN;
      S_MARK:     cmd.op = OP_SET;
      S_DIV_LOAD: cmd.op = OP_DIV_LOAD;
      S_RANGE:    cmd.op = OP_RANGE;
      S_CHECK:    cmd.op = OP_CHECK;
      S_UNMARK:   cmd.op = OP_UNSET;
      S_FINISH:   cmd.op = load ? OP_OUT : OP_NONE;
      default:    cmd.op = OP_NONE;
    endcase
    out_valid_next = load | (out_valid & ~out_ready);
  end

endmodule

// File: rtl/bpa_dp.sv
// Datapath of the bitmap page allocator: registers, used-bit memory, scan and
// range logic. Depends on bpa_pkg and instantiates bpa_div.
module bpa_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_en,
  input  logic [bpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpa_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_mode,
  input  logic [1:0]                    in_pool,
  input  logic [bpa_pkg::ADDR_W-1:0]    in_address,
  input  logic [bpa_pkg::CNT_W-1:0]     in_page_count,
  output logic [bpa_pkg::ADDR_W-1:0]    res_page_address,
  output logic [2:0]                    res_status,
  input  bpa_pkg::cmd_t                 cmd,
  output bpa_pkg::sts_t                 sts
);
  import bpa_pkg::*;

  localparam int CMP_W = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
  localparam int PA_W  = CFG_W + 1 + PB_W;

  function automatic logic [SIZE_W-1:0] span(input logic [CFG_W-1:0] lo,
                                             input logic [CFG_W-1:0] hi);
    logic [CFG_W-1:0] d;
    d = hi - lo;
    if (hi <= lo) span = '0;
    else if (d > CFG_W'(POOL_PAGES)) span = SIZE_W'(POOL_PAGES);
    else span = d[SIZE_W-1:0];
  endfunction

  logic [CFG_W-1:0]  kfp, ufp, uep;
  logic [PROD_W-1:0] kb, ub, eb;
  logic [SIZE_W-1:0] ksize, usize;

  logic              req_mode;
  logic [1:0]        req_pool;
  logic [ADDR_W-1:0] req_addr;
  logic [CNT_W-1:0]  req_cnt;

  logic              sel_r;
  logic [SIZE_W-1:0] size_r;
  logic [CFG_W-1:0]  first_r;
  logic [PROD_W-1:0] base_r;

  logic [SIZE_W-1:0] issue_ptr, test_ptr, run;
  logic              test_vld;
  logic [IDX_W-1:0]  lo_r, hi_r;
  logic [ROW_W-1:0]  row_issue, row_test;
  logic              row_vld;
  logic              any_r;
  logic [ADDR_W-1:0] pa_r;
  logic [MEM_AW-1:0] clr_ptr;

  logic [WORD_BITS-1:0] mem [2**MEM_AW];
  logic [WORD_BITS-1:0] rd_data;
  logic [MEM_AW-1:0]    rd_addr, wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic                 wr_en;

  logic [PROD_W-1:0] addr_x;
  logic              in_k, in_u, sel_d;
  logic [SIZE_W-1:0] size_a;
  logic              bit_used;
  logic [SIZE_W-1:0] run_next;
  logic [CMP_W-1:0]  lo_full;
  logic [ROW_W-1:0]  lo_row, hi_row;
  logic [WB_W-1:0]   lo_b, hi_b;
  logic [WORD_BITS-1:0] mask;
  logic              row_hit;
  logic [ADDR_W-1:0] quot, idx_s, idx_c, hi_full;
  logic              div_start;
  logic [CFG_W:0]    pa_sum;
  logic              pass_op;

  bpa_div u_div (
    .clk      (clk),
    .start    (div_start),
    .dividend (req_addr - base_r[ADDR_W-1:0]),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      kfp <= KERNEL_FIRST_RST;
      ufp <= USER_FIRST_RST;
      uep <= USER_END_RST;
    end else if (cfg_en) begin
      if (cfg_index == REG_KERNEL_FIRST) kfp <= cfg_data;
      if (cfg_index == REG_USER_FIRST)   ufp <= cfg_data;
      if (cfg_index == REG_USER_END)     uep <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    kb    <= PROD_W'(kfp) << PB_SHIFT;
    ub    <= PROD_W'(ufp) << PB_SHIFT;
    eb    <= PROD_W'(uep) << PB_SHIFT;
    ksize <= span(kfp, ufp);
    usize <= span(ufp, uep);
    pa_r  <= ADDR_W'(PA_W'(pa_sum) << PB_SHIFT);
  end

  always_comb begin
    addr_x       = PROD_W'(req_addr);
    in_k         = (kb <= addr_x) && (addr_x < ub);
    in_u         = (ub <= addr_x) && (addr_x < eb);
    size_a       = (req_pool == POOL_USER) ? usize : ksize;
    sel_d        = (req_mode == MODE_FREE) ? !in_k : (req_pool == POOL_USER);
    sts.is_free  = (req_mode == MODE_FREE);
    sts.cnt_zero = (req_cnt == '0);
    sts.pool_bad = (req_pool != POOL_KERNEL) && (req_pool != POOL_USER);
    sts.no_room  = CMP_W'(req_cnt) > CMP_W'(size_a);
    sts.addr_bad = (req_addr == '0) || !(in_k || in_u);

    bit_used      = rd_data[test_ptr[WB_W-1:0]];
    run_next      = bit_used ? '0 : run + 1'b1;
    sts.scan_hit  = test_vld && (CMP_W'(run_next) == CMP_W'(req_cnt));
    sts.scan_miss = test_vld && !sts.scan_hit && (test_ptr == size_r - 1'b1);
    lo_full       = CMP_W'(test_ptr) + 1'b1 - CMP_W'(req_cnt);

    lo_row       = lo_r[IDX_W-1:WB_W];
    hi_row       = hi_r[IDX_W-1:WB_W];
    lo_b         = (row_test == lo_row) ? lo_r[WB_W-1:0] : '0;
    hi_b         = (row_test == hi_row) ? hi_r[WB_W-1:0] : '1;
    mask         = ({WORD_BITS{1'b1}} << lo_b) & ({WORD_BITS{1'b1}} >> (~hi_b));
    row_hit      = |(rd_data & mask);
    sts.pass_end = row_vld && (row_test == hi_row);
    sts.any_used = any_r | row_hit;

    idx_s         = ADDR_W'(size_r);
    idx_c         = ADDR_W'(req_cnt);
    sts.range_bad = (quot > idx_s) || (idx_c > idx_s - quot);
    hi_full       = quot + idx_c - 1'b1;

    sts.clr_end = (clr_ptr == '1);
    div_start   = (cmd.op == OP_DIV_LOAD);
    pa_sum      = {1'b0, first_r} + (CFG_W + 1)'(lo_r);
    pass_op     = (cmd.op == OP_SET) || (cmd.op == OP_CHECK) || (cmd.op == OP_UNSET);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr <= '0;
    end else if (cmd.op == OP_CLR) begin
      clr_ptr <= clr_ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LATCH) begin
      req_mode <= in_mode;
      req_pool <= in_pool;
      req_addr <= in_address;
      req_cnt  <= in_page_count;
    end
    if (cmd.op == OP_DECODE) begin
      sel_r     <= sel_d;
      size_r    <= sel_d ? usize : ksize;
      first_r   <= sel_d ? ufp : kfp;
      base_r    <= sel_d ? ub : kb;
      issue_ptr <= '0;
      test_vld  <= 1'b0;
      run       <= '0;
    end
    if (cmd.op == OP_SCAN) begin
      issue_ptr <= issue_ptr + 1'b1;
      test_ptr  <= issue_ptr;
      test_vld  <= issue_ptr < size_r;
      if (test_vld) run <= run_next;
      if (sts.scan_hit) begin
        lo_r      <= lo_full[IDX_W-1:0];
        hi_r      <= test_ptr[IDX_W-1:0];
        row_issue <= lo_full[IDX_W-1:WB_W];
        row_vld   <= 1'b0;
      end
    end
    if (cmd.op == OP_RANGE) begin
      lo_r      <= quot[IDX_W-1:0];
      hi_r      <= hi_full[IDX_W-1:0];
      row_issue <= quot[IDX_W-1:WB_W];
      row_vld   <= 1'b0;
      any_r     <= 1'b0;
    end
    if (pass_op) begin
      if (sts.pass_end) begin
        row_issue <= lo_row;
        row_vld   <= 1'b0;
      end else begin
        row_issue <= row_issue + 1'b1;
        row_test  <= row_issue;
        row_vld   <= 1'b1;
      end
    end
    if (cmd.op == OP_CHECK) begin
      any_r <= any_r | (row_vld & row_hit);
    end
    if (cmd.op == OP_OUT) begin
      res_status <= cmd.code;
      res_page_address <= ((cmd.code == ST_OK) && (req_mode == MODE_ALLOC)) ? pa_r : '0;
    end
  end

  always_comb begin
    rd_addr = (cmd.op == OP_SCAN) ? {sel_r, issue_ptr[IDX_W-1:WB_W]} : {sel_r, row_issue};
    wr_en   = 1'b0;
    wr_addr = {sel_r, row_test};
    wr_data = rd_data | mask;
    unique case (cmd.op)
      OP_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_ptr;
        wr_data = (clr_ptr[ROW_W-1:0] == '0) ? WORD_BITS'(1) : '0;
      end
      OP_SET: begin
        wr_en = row_vld;
      end
      OP_UNSET: begin
        wr_en   = row_vld;
        wr_data = rd_data & ~mask;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

endmodule

// File: rtl/bitmap_page_allocator.sv
// Top level of the bitmap page allocator: sequencer plus datapath.
// Depends on bpa_pkg, bpa_if, bpa_ctrl, bpa_dp and bpa_div.
//
// Two pools of 1024 pages each keep one used bit per page in a single memory of
// 32-bit rows. The block works on one request at a time and returns one result
// word per request word; a finished result waits in an output register while
// the next request word is taken. An allocate decodes the request, runs a
// first-fit scan over the pages of the pool (up to the pool size), one page
// per cycle from the memory read port, and then makes a pass that sets the
// used bits of each 32-page row the found run touches. A free finds its pool
// and page index (a shift by the page size), then makes a pass over the rows
// of the range to test them and, if a page is used, a second pass to clear
// them, and then outputs its result. Requests that fail early go straight to
// the output step. After reset a clearing pass, one row a cycle, writes the
// reset maps, and no request word is taken during it; configuration writes
// are taken at any time.
module bitmap_page_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_en,
  input  logic [bpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpa_pkg::CFG_W-1:0]     cfg_data,
  bpa_req_if.sink                       req,
  bpa_res_if.source                     res
);
  import bpa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bpa_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_en           (cfg_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_mode          (req.mode),
    .in_pool          (req.pool),
    .in_address       (req.address),
    .in_page_count    (req.page_count),
    .res_page_address (res.page_address),
    .res_status       (res.status),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule

// File: rtl/bpa_checker.sv
// Port-level checks of the bitmap page allocator and the bind that attaches
// them to the top level. Depends on bpa_pkg for widths and status codes.
module bpa_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic                       res_valid,
  input logic                       res_ready,
  input logic [bpa_pkg::ADDR_W-1:0] page_address,
  input logic [2:0]                 status
);
  import bpa_pkg::*;

  logic [1:0] pend;
  logic       req_acc, res_acc;

  assign req_acc = req_valid && req_ready;
  assign res_acc = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 2'd0;
    end else if (req_acc && !res_acc) begin
      pend <= pend + 2'd1;
    end else if (res_acc && !req_acc) begin
      pend <= pend - 2'd1;
    end
  end

  a_no_orphan_result: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> pend != 2'd0)
    else $error("result word shown with no request outstanding");

  a_two_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_acc |-> pend != 2'd2)
    else $error("request word taken with two words already in flight");

  a_fail_zero_address: assert property (@(posedge clk) disable iff (rst)
    res_valid && (status != ST_OK) |-> page_address == '0)
    else $error("failed request returned a nonzero page address");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(page_address) && $stable(status))
    else $error("stalled result word changed");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !res_valid && !req_ready)
    else $error("block active right after reset");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .page_address (res.page_address),
  .status       (res.status)
);

// File: tb/sv/tb_bitmap_page_allocator.sv
// Testbench for the bitmap page allocator: directed and random allocate and free
// requests, each result word checked against an in-bench model of both pool maps.
// Depends on bpa_pkg, the bpa_if channel interfaces and the bitmap_page_allocator RTL.
`timescale 1ns / 1ps

module tb_bitmap_page_allocator;
  import bpa_pkg::*;

  localparam int CYCLE_LIMIT = 4_000_000;

  typedef struct packed {
    logic [ADDR_W-1:0] page_address;
    status_t           status;
  } outcome_t;

  typedef struct {
    logic [ADDR_W-1:0] address;
    int unsigned       pages;
  } run_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  bpa_req_if req_ch ();
  bpa_res_if res_ch ();

  bitmap_page_allocator u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .res       (res_ch)
  );

  logic             used_map [2][POOL_PAGES];
  logic [CFG_W-1:0] kernel_first;
  logic [CFG_W-1:0] user_first;
  logic [CFG_W-1:0] user_end;
  outcome_t         awaited_q [$];
  run_t             live_runs [$];

  int send_idle;
  int recv_idle;
  int hold_len;
  int hold_seq;
  int hold_seen;
  int hold_left;
  int cycles;
  int words_sent;
  int words_checked;
  int mismatches;
  int layouts;
  int status_count [6];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("bitmap_page_allocator verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin : drive_ready
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk) begin : check_results
    outcome_t want;
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (awaited_q.size() == 0) begin
        $error("unexpected result word: page_address %h, status %0d",
               res_ch.page_address, res_ch.status);
        mismatches++;
      end else begin
        want = awaited_q.pop_front();
        words_checked++;
        status_count[int'(want.status)]++;
        if (res_ch.page_address !== want.page_address) begin
          $error("page_address mismatch: expected %h, actual %h",
                 want.page_address, res_ch.page_address);
          mismatches++;
        end
        if (res_ch.status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, res_ch.status);
          mismatches++;
        end
      end
    end
  end

  function automatic longint unsigned pool_pages(logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi);
    if (hi <= lo) return 0;
    if (hi - lo > POOL_PAGES) return POOL_PAGES;
    return hi - lo;
  endfunction

  function automatic logic [ADDR_W-1:0] page_at(logic [CFG_W-1:0] first_page, int unsigned idx);
    longint unsigned a;
    a = first_page;
    a = (a + idx) * PAGE_BYTES;
    return a[ADDR_W-1:0];
  endfunction

  function automatic outcome_t allocate_pages(logic [1:0] pool, int unsigned cnt);
    outcome_t        o;
    longint unsigned size;
    longint unsigned start;
    longint unsigned run;
    int              p;
    o.page_address = '0;
    o.status = ST_OK;
    if (cnt == 0) begin
      o.status = ST_ZERO;
      return o;
    end
    if (pool == POOL_KERNEL) begin
      p = POOL_KERNEL;
      start = kernel_first;
      size = pool_pages(kernel_first, user_first);
    end else if (pool == POOL_USER) begin
      p = POOL_USER;
      start = user_first;
      size = pool_pages(user_first, user_end);
    end else begin
      o.status = ST_BADPOOL;
      return o;
    end
    o.status = ST_NOSPACE;
    if (cnt > size) return o;
    run = 0;
    for (longint unsigned i = 0; i < size; i++) begin
      run = used_map[p][i] ? 0 : run + 1;
      if (run == cnt) begin
        for (longint unsigned k = i + 1 - cnt; k <= i; k++) used_map[p][k] = 1'b1;
        o.page_address = ADDR_W'((start + i + 1 - cnt) * PAGE_BYTES);
        o.status = ST_OK;
        live_runs.push_back('{o.page_address, cnt});
        return o;
      end
    end
    return o;
  endfunction

  function automatic outcome_t free_pages(logic [ADDR_W-1:0] address, int unsigned cnt);
    outcome_t        o;
    longint unsigned addr;
    longint unsigned kb;
    longint unsigned ub;
    longint unsigned eb;
    longint unsigned base;
    longint unsigned size;
    longint unsigned idx;
    int              p;
    bit              hit;
    o.page_address = '0;
    o.status = ST_OK;
    addr = address;
    kb = kernel_first;
    kb = kb * PAGE_BYTES;
    ub = user_first;
    ub = ub * PAGE_BYTES;
    eb = user_end;
    eb = eb * PAGE_BYTES;
    hit = 1'b0;
    if (cnt == 0) begin
      o.status = ST_ZERO;
    end else if (addr == 0) begin
      o.status = ST_BADPOOL;
    end else if (kb <= addr && addr < ub) begin
      p = POOL_KERNEL;
      base = kb;
      size = pool_pages(kernel_first, user_first);
    end else if (ub <= addr && addr < eb) begin
      p = POOL_USER;
      base = ub;
      size = pool_pages(user_first, user_end);
    end else begin
      o.status = ST_BADPOOL;
    end
    if (o.status != ST_OK) return o;
    idx = (addr - base) / PAGE_BYTES;
    if (idx > size || cnt > size - idx) begin
      o.status = ST_RANGE;
      return o;
    end
    for (longint unsigned k = idx; k < idx + cnt; k++) if (used_map[p][k]) hit = 1'b1;
    if (!hit) begin
      o.status = ST_NOTUSED;
      return o;
    end
    for (longint unsigned k = idx; k < idx + cnt; k++) used_map[p][k] = 1'b0;
    return o;
  endfunction

  task automatic send_word(mode_t mode, logic [1:0] pool, logic [ADDR_W-1:0] address,
                           logic [CNT_W-1:0] cnt);
    while (send_idle > 0 && $urandom_range(0, 99) < send_idle) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.mode       <= mode;
    req_ch.pool       <= pool;
    req_ch.address    <= address;
    req_ch.page_count <= cnt;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    if (mode == MODE_ALLOC) awaited_q.push_back(allocate_pages(pool, cnt));
    else awaited_q.push_back(free_pages(address, cnt));
    words_sent++;
  endtask

  task automatic quiesce();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (awaited_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_pools(logic [CFG_W-1:0] k, logic [CFG_W-1:0] u, logic [CFG_W-1:0] e);
    cfg_en    <= 1'b1;
    cfg_index <= REG_KERNEL_FIRST;
    cfg_data  <= k;
    @(posedge clk);
    kernel_first = k;
    cfg_index <= REG_USER_FIRST;
    cfg_data  <= u;
    @(posedge clk);
    user_first = u;
    cfg_index <= REG_USER_END;
    cfg_data  <= e;
    @(posedge clk);
    user_end = e;
    cfg_en <= 1'b0;
    live_runs.delete();
    layouts++;
  endtask

  // Most words are allocations and frees of runs handed out earlier; the rest
  // are frees at arbitrary addresses and counts.
  task automatic send_random_word();
    int unsigned       r;
    int unsigned       j;
    run_t              rn;
    logic [1:0]        pool;
    logic [CNT_W-1:0]  cnt;
    logic [ADDR_W-1:0] address;
    logic [CFG_W-1:0]  lo;
    longint unsigned   span;
    longint unsigned   a;
    r = $urandom_range(0, 99);
    pool = $urandom_range(0, 3);
    address = $urandom();
    if (r < 45) begin
      if ($urandom_range(0, 19) != 0) pool = $urandom_range(0, 1);
      r = $urandom_range(0, 99);
      if (r < 3) cnt = 0;
      else if (r < 80) cnt = $urandom_range(1, 8);
      else if (r < 95) cnt = $urandom_range(1, 64);
      else cnt = $urandom_range(1, POOL_PAGES);
      send_word(MODE_ALLOC, pool, address, cnt);
    end else if (r < 82 && live_runs.size() != 0) begin
      j = $urandom_range(0, live_runs.size() - 1);
      rn = live_runs[j];
      live_runs.delete(j);
      address = rn.address;
      if ($urandom_range(0, 3) == 0) address = address + $urandom_range(0, PAGE_BYTES - 1);
      cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(1, rn.pages) : rn.pages;
      send_word(MODE_FREE, pool, address, cnt);
    end else begin
      r = $urandom_range(0, 1);
      lo = r ? user_first : kernel_first;
      span = r ? pool_pages(user_first, user_end) : pool_pages(kernel_first, user_first);
      a = lo;
      a = (a + $urandom_range(0, span + 4)) * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1);
      if ($urandom_range(0, 2) != 0) address = a[ADDR_W-1:0];
      cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, POOL_PAGES) : $urandom_range(0, 16);
      send_word(MODE_FREE, pool, address, cnt);
    end
  endtask

  task automatic test_directed_requests();
    send_word(MODE_ALLOC, POOL_KERNEL, '0, 1);
    send_word(MODE_ALLOC, POOL_USER, 32'hFFFF_FFFF, POOL_PAGES);
    send_word(MODE_ALLOC, POOL_USER, '0, POOL_PAGES - 1);
    send_word(MODE_ALLOC, POOL_USER, '0, 1);
    send_word(MODE_ALLOC, POOL_KERNEL, '0, 0);
    send_word(MODE_FREE, 2'd3, page_at(user_first, 5), 0);
    send_word(MODE_ALLOC, 2'd2, '0, 4);
    send_word(MODE_ALLOC, 2'd3, '0, 4);
    send_word(MODE_FREE, POOL_KERNEL, '0, 1);
    send_word(MODE_FREE, POOL_KERNEL, 32'hFFFF_FFFF, 1);
    send_word(MODE_FREE, POOL_KERNEL, page_at(kernel_first, 0) - 1, 1);
    send_word(MODE_FREE, POOL_KERNEL, page_at(kernel_first, 1) + 32'h123, 1);
    send_word(MODE_FREE, POOL_KERNEL, page_at(kernel_first, 1), 1);
    send_word(MODE_FREE, POOL_USER, page_at(user_first, POOL_PAGES - 1), 2);
    send_word(MODE_FREE, POOL_USER, page_at(user_first, POOL_PAGES) - 1, 1);
    send_word(MODE_FREE, POOL_USER, page_at(user_first, 1), POOL_PAGES - 1);
    send_word(MODE_FREE, POOL_USER, page_at(user_first, 0), POOL_PAGES);
    send_word(MODE_FREE, POOL_KERNEL, page_at(kernel_first, 0), 1);
    send_word(MODE_ALLOC, POOL_KERNEL, '0, POOL_PAGES);
    send_word(MODE_FREE, POOL_KERNEL, page_at(kernel_first, 0), POOL_PAGES);
    send_word(MODE_ALLOC, POOL_KERNEL, '0, 3);
    send_word(MODE_ALLOC, POOL_KERNEL, '0, 2);
    send_word(MODE_FREE, POOL_KERNEL, page_at(kernel_first, 1), 1);
    send_word(MODE_ALLOC, POOL_KERNEL, '0, 2);
    send_word(MODE_ALLOC, POOL_KERNEL, '0, 1);
    quiesce();
  endtask

  task automatic test_pool_layouts();
    set_pools(20'h0, 20'h0, 20'hFFFFF);
    send_word(MODE_ALLOC, POOL_KERNEL, '0, 1);
    send_word(MODE_FREE, POOL_USER, '0, 1);
    send_word(MODE_FREE, POOL_USER, 32'h0000_0FFF, 1);
    send_word(MODE_FREE, POOL_USER, 32'hFFFF_FFFF, 1);
    send_word(MODE_ALLOC, POOL_USER, '0, 2);
    quiesce();
    set_pools(20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
    send_word(MODE_ALLOC, POOL_KERNEL, '0, 1);
    send_word(MODE_ALLOC, POOL_USER, '0, 1);
    send_word(MODE_FREE, POOL_KERNEL, 32'hFFFF_F000, 1);
    quiesce();
    set_pools(20'd10, 20'd5, 20'd3);
    send_word(MODE_ALLOC, POOL_USER, '0, 1);
    send_word(MODE_FREE, POOL_KERNEL, page_at(20'd5, 0), 1);
    quiesce();
    set_pools(20'd1, 20'd9, 20'd17);
    send_word(MODE_ALLOC, POOL_KERNEL, '0, 9);
    send_word(MODE_ALLOC, POOL_KERNEL, '0, 8);
    send_word(MODE_ALLOC, POOL_USER, '0, 4);
    send_word(MODE_FREE, POOL_USER, page_at(20'd17, 0), 1);
    send_word(MODE_FREE, POOL_USER, page_at(20'd9, 7), 2);
    send_word(MODE_FREE, POOL_USER, page_at(20'd9, 7), 1);
    send_word(MODE_FREE, POOL_KERNEL, page_at(20'd1, 0), 8);
    quiesce();
    set_pools(20'hFFC00, 20'hFFE00, 20'hFFFFF);
    send_word(MODE_ALLOC, POOL_KERNEL, '0, 4);
    send_word(MODE_ALLOC, POOL_USER, '0, 4);
    send_word(MODE_FREE, POOL_USER, page_at(user_first, 510), 1);
    send_word(MODE_FREE, POOL_USER, page_at(user_first, 511), 1);
    send_word(MODE_FREE, POOL_KERNEL, page_at(kernel_first, 0), 4);
    quiesce();
  endtask

  task automatic run_random(int n);
    repeat (n) send_random_word();
    quiesce();
  endtask

  task automatic test_random_sender_gaps();
    send_idle = 35;
    recv_idle = 70;
    set_pools(20'd16, 20'd80, 20'd144);
    run_random(175);
  endtask

  task automatic test_random_receiver_gaps();
    send_idle = 70;
    recv_idle = 35;
    set_pools(KERNEL_FIRST_RST, USER_FIRST_RST, USER_END_RST);
    run_random(175);
  endtask

  task automatic test_random_streaming();
    send_idle = 0;
    recv_idle = 0;
    set_pools(20'd100, 20'd400, 20'd2000);
    run_random(165);
  endtask

  task automatic test_backpressure();
    send_idle = 0;
    recv_idle = 0;
    hold_len = 300;
    hold_seq++;
    repeat (16) send_random_word();
    quiesce();
    repeat (8) send_random_word();
    quiesce();
  endtask

  initial begin
    rst = 1'b1;
    cfg_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.mode = MODE_ALLOC;
    req_ch.pool = '0;
    req_ch.address = '0;
    req_ch.page_count = '0;
    res_ch.ready = 1'b0;
    for (int i = 0; i < POOL_PAGES; i++) begin
      used_map[POOL_KERNEL][i] = (i == 0);
      used_map[POOL_USER][i] = (i == 0);
    end
    kernel_first = KERNEL_FIRST_RST;
    user_first = USER_FIRST_RST;
    user_end = USER_END_RST;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_directed_requests();
    test_pool_layouts();
    test_random_sender_gaps();
    test_random_receiver_gaps();
    test_random_streaming();
    test_backpressure();

    if (awaited_q.size() != 0) begin
      $error("%0d expected result words never arrived", awaited_q.size());
      mismatches++;
    end
    $display("Checked %0d result words for %0d request words over %0d pool layouts.",
             words_checked, words_sent, layouts + 1);
    $display("Status mix: ok %0d, zero count %0d, no space %0d, bad pool/address %0d, %s%0d, %s%0d.",
             status_count[ST_OK], status_count[ST_ZERO], status_count[ST_NOSPACE],
             status_count[ST_BADPOOL], "nothing used ", status_count[ST_NOTUSED],
             "out of range ", status_count[ST_RANGE]);
    if (mismatches == 0) begin
      $display("bitmap_page_allocator verification clean");
    end else begin
      $display("bitmap_page_allocator verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/bpa_pkg.sv
rtl/bpa_if.sv
rtl/bpa_div.sv
rtl/bpa_ctrl.sv
rtl/bpa_dp.sv
rtl/bitmap_page_allocator.sv
rtl/bpa_checker.sv
tb/sv/tb_bitmap_page_allocator.sv
